/* hdl/pli_pkg.sv */
`default_nettype none
package pli_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned PROD_W = 64;

  // scale of one in Q16.16, used as the multiplier for the slope quotient
  localparam logic [DIFF_W-1:0] FRAC_ONE = 33'd65536;

  localparam logic IN_KIND_LOAD = 1'b0;
  localparam logic IN_KIND_EVAL = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] mcand;
    logic [DIFF_W-1:0] mplier;
    logic [DIFF_W-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

endpackage
`default_nettype wire

/* hdl/pli_bp_mem.sv */
`default_nettype none
module pli_bp_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hdl/pli_muldiv.sv */
`default_nettype none
module pli_muldiv (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pli_pkg::md_req_t req,
  output pli_pkg::md_rsp_t     rsp
);
  import pli_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} md_state_t;

  md_state_t         state_r;
  logic [6:0]        cnt_r;
  logic [PROD_W-1:0] mcand_r;
  logic [DIFF_W-1:0] mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [DIFF_W-1:0] den_r;
  logic [DIFF_W-1:0] rem_r;
  logic              done_r;

  logic [DIFF_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem_r, acc_r[PROD_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            mcand_r  <= {{(PROD_W-DIFF_W){1'b0}}, req.mcand};
            mplier_r <= req.mplier;
            den_r    <= req.den;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          // shift-add, one multiplier bit per cycle
          if (mplier_r[0]) begin
            acc_r <= acc_r + mcand_r;
          end
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          if (cnt_r == 7'(DIFF_W - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_DIV: begin
          // restoring divide, quotient bits shift into the product register
          rem_r <= qbit ? DIFF_W'(rem_sh - {1'b0, den_r}) : DIFF_W'(rem_sh);
          acc_r <= {acc_r[PROD_W-2:0], qbit};
          if (cnt_r == 7'(PROD_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != ST_IDLE);
  assign rsp.done = done_r;
  assign rsp.quot = acc_r;

endmodule
`default_nettype wire

/* hdl/piecewise_linear_interpolator_unit.sv */
// Breakpoint-table interpolator, signed Q16.16. An input beat with in_tuser low stores
// breakpoint (load_point, load_value) at entry_index and returns nothing.
// A beat with in_tuser high evaluates at eval_x and returns one result beat: the table
// is read from a synchronous memory with one read and one write port, one entry per
// cycle, then a shared shift-add multiplier and restoring divider produce the slope
// and the interpolated value in turn. An evaluation at or beyond either end returns
// that end's ordinate without using the divider. Value and slope saturate to 32 bits
// and divisions truncate toward zero; table_ok reports whether the active abscissas
// are nondecreasing. Entries must be loaded before they are evaluated. cfg_wr_data
// sets active_points (reset 2).
`default_nettype none
module piecewise_linear_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [4:0]    cfg_wr_data,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // entry_index[3:0], load_point[35:4], load_value[67:36], eval_x[99:68]
  input  wire logic [103:0]  in_tdata,
  // kind[0]
  input  wire logic          in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // interp_value[31:0], interp_slope[63:32], table_ok[64], saturated[65]
  output logic [71:0]        out_tdata
);
  import pli_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW = 2 * WORD_W;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_SLOPE, ST_VALUE, ST_FIN}
    state_t;

  state_t            state_r;
  logic [4:0]        active_r;
  logic [AW-1:0]     last_r;
  logic [AW-1:0]     iss_r;
  logic              issuing_r;
  logic              dvld_r;
  logic [AW-1:0]     didx_r;
  logic signed [WORD_W-1:0] x_r, x0_r, y0_r, xl_r, yl_r, px_r, py_r;
  logic signed [WORD_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic              found_r, ok_r, clip_r, neg_r;
  logic [DIFF_W-1:0] mag_r, dx_r, t_r;
  logic signed [WORD_W-1:0] slope_r;
  logic              out_tvalid_r;
  logic [71:0]       out_tdata_r;
  logic signed [WORD_W-1:0] res_val_r;

  logic [3:0]        in_entry;
  logic [WORD_W-1:0] in_point, in_value, in_x;
  logic              in_acc;
  logic              mem_we;
  logic [EW-1:0]     rd_data;
  logic signed [WORD_W-1:0] cur_x, cur_y;
  logic [AW-1:0]     last_nxt;
  logic signed [DIFF_W-1:0] dy_s;
  logic [DIFF_W-1:0] mag_nxt, dx_nxt, t_nxt;
  logic signed [DIFF_W+1:0] sum_s;
  logic [DIFF_W:0]   q_val;
  md_req_t           md_req;
  md_rsp_t           md_rsp;

  assign in_entry = in_tdata[3:0];
  assign in_point = in_tdata[35:4];
  assign in_value = in_tdata[67:36];
  assign in_x     = in_tdata[99:68];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign mem_we   = in_acc && (in_tuser == IN_KIND_LOAD) && (32'(in_entry) < TABLE_DEPTH);
  assign cur_x    = rd_data[WORD_W-1:0];
  assign cur_y    = rd_data[EW-1:WORD_W];

  always_comb begin
    if (active_r == 5'd0) begin
      last_nxt = '0;
    end else if (32'(active_r) >= TABLE_DEPTH) begin
      last_nxt = AW'(TABLE_DEPTH - 1);
    end else begin
      last_nxt = AW'(active_r - 5'd1);
    end
  end

  pli_bp_mem #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(EW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_entry)),
    .wr_data ({in_value, in_point}),
    .rd_addr (iss_r),
    .rd_data (rd_data)
  );

  pli_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign dy_s    = DIFF_W'(y2_r) - DIFF_W'(y1_r);
  assign mag_nxt = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);
  assign dx_nxt  = DIFF_W'(x2_r) - DIFF_W'(x1_r);
  assign t_nxt   = DIFF_W'(x_r) - DIFF_W'(x1_r);
  assign q_val = md_rsp.quot[DIFF_W:0];
  assign sum_s = neg_r ? ((DIFF_W+2)'(y1_r) - (DIFF_W+2)'({1'b0, q_val}))
                       : ((DIFF_W+2)'(y1_r) + (DIFF_W+2)'({1'b0, q_val}));

  always_comb begin
    md_req.start  = 1'b0;
    md_req.mcand  = mag_r;
    md_req.mplier = FRAC_ONE;
    md_req.den    = dx_r;
    if (state_r == ST_DECIDE) begin
      // operand registers load on this edge, so feed their next values
      md_req.start = !(x_r <= x0_r) && !(x_r >= xl_r);
      md_req.mcand = mag_nxt;
      md_req.den   = dx_nxt;
    end else if (state_r == ST_SLOPE && md_rsp.done) begin
      md_req.start  = 1'b1;
      md_req.mplier = t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 5'd2;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issuing_r    <= 1'b0;
      dvld_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      iss_r        <= '0;
    end else begin
      if (state_r == ST_FIN && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      dvld_r <= issuing_r;
      didx_r <= iss_r;
      if (issuing_r) begin
        if (iss_r == last_r) begin
          issuing_r <= 1'b0;
        end else begin
          iss_r <= iss_r + AW'(1);
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == IN_KIND_EVAL)) begin
            x_r       <= in_x;
            last_r    <= last_nxt;
            iss_r     <= '0;
            issuing_r <= 1'b1;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (dvld_r) begin
            px_r <= cur_x;
            py_r <= cur_y;
            if (didx_r == '0) begin
              x0_r    <= cur_x;
              y0_r    <= cur_y;
              found_r <= 1'b0;
              ok_r    <= 1'b1;
            end else begin
              if (cur_x < px_r) begin
                ok_r <= 1'b0;
              end
              // first point at or above x, or the last active point, closes the segment
              if (!found_r && (x_r <= cur_x || didx_r == last_r)) begin
                found_r <= 1'b1;
                x1_r    <= px_r;
                y1_r    <= py_r;
                x2_r    <= cur_x;
                y2_r    <= cur_y;
              end
            end
            if (didx_r == last_r) begin
              xl_r    <= cur_x;
              yl_r    <= cur_y;
              state_r <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          clip_r  <= 1'b0;
          slope_r <= '0;
          if (x_r <= x0_r) begin
            res_val_r <= y0_r;
            state_r   <= ST_FIN;
          end else if (x_r >= xl_r) begin
            res_val_r <= yl_r;
            state_r   <= ST_FIN;
          end else begin
            state_r <= ST_SLOPE;
          end
        end
        ST_SLOPE: begin
          if (md_rsp.done) begin
            if (neg_r) begin
              if (md_rsp.quot > 64'h8000_0000) begin
                slope_r <= 32'sh8000_0000;
                clip_r  <= 1'b1;
              end else begin
                slope_r <= WORD_W'(-md_rsp.quot);
              end
            end else if (md_rsp.quot > 64'h7FFF_FFFF) begin
              slope_r <= 32'sh7FFF_FFFF;
              clip_r  <= 1'b1;
            end else begin
              slope_r <= WORD_W'(md_rsp.quot);
            end
            state_r <= ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (md_rsp.done) begin
            if (sum_s > (DIFF_W+2)'(32'sh7FFF_FFFF)) begin
              res_val_r <= 32'sh7FFF_FFFF;
              clip_r    <= 1'b1;
            end else if (sum_s < -(DIFF_W+2)'(64'sh8000_0000)) begin
              res_val_r <= 32'sh8000_0000;
              clip_r    <= 1'b1;
            end else begin
              res_val_r <= WORD_W'(sum_s);
            end
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {6'd0, clip_r, ok_r, slope_r, res_val_r};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // segment operands, held from the decision through both quotients
  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      neg_r <= dy_s[DIFF_W-1];
      mag_r <= mag_nxt;
      dx_r  <= dx_nxt;
      t_r   <= t_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_ready_no_md: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !md_rsp.busy)
    else $error("input ready while divider busy");
  a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> (state_r == ST_SCAN))
    else $error("evaluate beat did not start scan");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && dvld_r) |-> (didx_r <= last_r))
    else $error("scan read beyond last active point");
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == ST_SLOPE || state_r == ST_VALUE))
    else $error("quotient returned outside arithmetic phase");
`endif

endmodule
`default_nettype wire

/* verif/piecewise_linear_interpolator_unit_test.sv */
`default_nettype none
module piecewise_linear_interpolator_unit_test;
  import pli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] ex;
  } lut_op_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] slope;
    logic        ok;
    logic        clip;
  } lut_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  piecewise_linear_interpolator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lut_op_t  pending_ops[$];
  lut_res_t expected_results[$];
  logic signed [31:0] pt_x[DEPTH];
  logic signed [31:0] pt_y[DEPTH];
  logic [4:0] num_points = 5'd2;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                 inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // trunc(mag * mul / den), both operands below 2^33 so the product fits 66 bits
  function automatic logic signed [63:0] scaled_quot(input logic neg, input logic [63:0] mag,
                                                     input logic [63:0] mul,
                                                     input logic [63:0] den);
    logic [127:0] q;
    q = (128'(mag) * 128'(mul)) / 128'(den);
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic void predict_interp(input lut_op_t op);
    int n, i;
    logic signed [63:0] x, x1, x2, y1, dy, dx, t, val, slope;
    logic [63:0] dy_mag;
    logic ok, clip, neg;
    lut_res_t r;
    if (op.kind == IN_KIND_LOAD) begin
      pt_x[op.slot] = op.px;
      pt_y[op.slot] = op.py;
      return;
    end
    n = int'(num_points);
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    ok = 1'b1;
    clip = 1'b0;
    slope = 0;
    for (i = 1; i < n; i++)
      if (pt_x[i] < pt_x[i-1]) ok = 1'b0;
    x = $signed(op.ex);
    if (x <= pt_x[0]) begin
      val = pt_y[0];
    end else if (x >= pt_x[n-1]) begin
      val = pt_y[n-1];
    end else begin
      i = 1;
      while (i < n - 1 && x > pt_x[i]) i++;
      x1 = pt_x[i-1];
      x2 = pt_x[i];
      y1 = pt_y[i-1];
      dy = pt_y[i] - y1;
      dx = x2 - x1;
      t = x - x1;
      neg = dy < 0;
      dy_mag = neg ? -dy : dy;
      slope = clamp32(scaled_quot(neg, dy_mag, 64'd65536, dx), clip);
      val = clamp32(y1 + scaled_quot(neg, dy_mag, t, dx), clip);
    end
    val = clamp32(val, clip);
    r.value = val[31:0];
    r.slope = slope[31:0];
    r.ok = ok;
    r.clip = clip;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // driver: predicts at acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_interp(lut_op_t'({in_tuser, in_tdata[3:0], in_tdata[35:4],
                                  in_tdata[67:36], in_tdata[99:68]}));
      if ((!in_tvalid || in_tready) && pending_ops.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        lut_op_t op;
        op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= op.kind;
        in_tdata <= {4'd0, op.ex, op.py, op.px, op.slot};
      end else if (in_tready) begin
        in_tvalid <= 1'b0;
      end
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        error_count++;
      end else begin
        lut_res_t e;
        e = expected_results.pop_front();
        if (out_tdata[31:0] !== e.value) begin
          $display("%0t: interp_value expected %h got %h", $time, e.value, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== e.slope) begin
          $display("%0t: interp_slope expected %h got %h", $time, e.slope, out_tdata[63:32]);
          error_count++;
        end
        if (out_tdata[64] !== e.ok) begin
          $display("%0t: table_ok expected %b got %b", $time, e.ok, out_tdata[64]);
          error_count++;
        end
        if (out_tdata[65] !== e.clip) begin
          $display("%0t: saturated expected %b got %b", $time, e.clip, out_tdata[65]);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("piecewise_linear_interpolator_unit_test: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(65536) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_load(input int s, input logic [31:0] px, input logic [31:0] py);
    lut_op_t op;
    op.kind = IN_KIND_LOAD;
    op.slot = 4'(s);
    op.px = px;
    op.py = py;
    op.ex = $urandom;
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic void queue_eval(input logic [31:0] ex);
    lut_op_t op;
    op.kind = IN_KIND_EVAL;
    op.slot = 4'($urandom);
    op.px = $urandom;
    op.py = $urandom;
    op.ex = ex;
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  // fills the whole table; abscissas sorted on request, else random; random ordinates
  function automatic void queue_table(input bit sorted);
    logic signed [31:0] xs[DEPTH];
    logic signed [31:0] step;
    int k;
    xs[0] = $urandom_range(3) == 0 ? 32'sh8000_0000 : -$signed(32'($urandom_range(1 << 24)));
    for (k = 1; k < DEPTH; k++) begin
      step = $urandom_range(3) == 0 ? 0 : $urandom_range(1 << 22);
      xs[k] = (xs[k-1] > 32'sh7000_0000) ? xs[k-1] : xs[k-1] + step;
    end
    for (k = 0; k < DEPTH; k++)
      queue_load(k, sorted ? xs[k] : rand_word(), rand_word());
  endfunction

  task automatic drain_and_config(input logic [4:0] pts);
    wait (pending_ops.size() == 0);
    @(posedge clk);
    while (in_tvalid || expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= pts;
    num_points <= pts;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int ph, k, idle_mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: reset count of two, steep and unit-slope segments, ends, clipping
    queue_load(0, 32'h8000_0000, 32'h8000_0000);
    queue_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_eval(32'h8000_0000);
    queue_eval(32'h7FFF_FFFF);
    queue_eval(32'h0000_0000);
    queue_eval(32'h8000_0001);
    queue_load(0, 32'h0000_0000, 32'h8000_0000);
    queue_load(1, 32'h0000_0001, 32'h7FFF_FFFF);
    queue_eval(32'h0000_0001);
    queue_eval(32'hFFFF_FFFF);
    queue_load(1, 32'h0000_0002, 32'h7FFF_FFFF);
    queue_eval(32'h0000_0001);
    queue_load(15, 32'h0001_0000, 32'h0002_0000);
    queue_load(0, 32'h0001_0000, 32'hFFFF_0000);
    queue_load(1, 32'h0003_0000, 32'h0001_0000);
    queue_eval(32'h0002_0000);
    queue_eval(32'h0002_8000);
    drain_and_config(5'd1);
    queue_eval(32'h1234_5678);
    queue_eval(32'h8000_0000);
    drain_and_config(5'd16);
    queue_table(1'b1);
    queue_eval(32'h7FFF_FFFF);
    queue_eval(32'h0000_0000);
    // random phases across counts and idle profiles
    for (ph = 0; ph < 16; ph++) begin
      idle_mode = ph % 4;
      send_idle_pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 27 : 0;
      recv_stall_pct = (idle_mode == 2) ? 84 : (idle_mode == 3) ? 27 : 0;
      for (k = 0; k < 3; k++) begin
        queue_table($urandom_range(5) != 0);
        repeat (10) begin
          if ($urandom_range(7) == 0) queue_load($urandom_range(15), rand_word(), rand_word());
          queue_eval($urandom_range(3) == 0 ? rand_word()
                                            : 32'($urandom_range(1 << 26)) - (1 << 25));
        end
      end
      drain_and_config(ph == 15 ? 5'd2 : (ph % 5 == 0) ? 5'd16 : (ph % 5 == 1) ? 5'd1
                                   : 5'($urandom_range(16, 1)));
    end
    recv_stall_pct = 0;
    wait (pending_ops.size() == 0);
    @(posedge clk);
    while (in_tvalid || expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) $display("piecewise_linear_interpolator_unit_test: done, clean");
    else $display("piecewise_linear_interpolator_unit_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
